// ----- rtl/core/vrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrc_pkg
// Shared widths, pipeline bundles and helpers for the cell exit step block.
// ----------------------------------------------------------------------------
package vrc_pkg;

  localparam int POS_W    = 32;
  localparam int DIR_W    = 16;
  localparam int CELL_W   = 16;
  localparam int LEN_W    = 20;
  localparam int FRAC_W   = 16;
  localparam int DELTA_W  = POS_W + 2;
  localparam int PROD_W   = DELTA_W + DIR_W;
  localparam int QUO_W    = 48;
  localparam int TRIAL_W  = 52;
  localparam int SQ_W     = 2 * LEN_W;
  localparam int SQ_IN_W  = 2 * LEN_W + 2;
  localparam int ROOT_W   = LEN_W + 1;
  localparam int SREM_W   = ROOT_W + 3;
  localparam int NLANE    = 6;

  // item context carried along the divider row
  typedef struct packed {
    logic [2:0][POS_W-1:0]   pos;
    logic [2:0][CELL_W-1:0]  cidx;
    logic [2:0][DELTA_W-1:0] delta;
    logic [2:0]              tried;
    logic [2:0]              up;
  } ctx_t;

  // one restoring-divide lane: partial remainder, numerator/quotient shifter
  typedef struct packed {
    logic [DIR_W-1:0] rem;
    logic [QUO_W-1:0] nq;
    logic [DIR_W-1:0] den;
    logic             neg;
  } lane_t;

  typedef struct packed {
    logic                   valid;
    ctx_t                   ctx;
    lane_t [NLANE-1:0]      lane;
  } div_t;

  // result fields carried along the root row
  typedef struct packed {
    logic [2:0][POS_W-1:0]  exit_p;
    logic [2:0][CELL_W-1:0] next_c;
    logic                   found;
    logic                   sat;
  } res_t;

  typedef struct packed {
    logic               valid;
    res_t               res;
    logic [SQ_IN_W-1:0] n;
    logic [SREM_W-1:0]  rem;
    logic [ROOT_W-1:0]  root;
  } sqrt_t;

  // axis of the j-th off-plane lane for a face on axis a
  function automatic logic [1:0] other_axis(input logic [1:0] a, input logic j);
    logic [1:0] k;
    case (a)
      2'd0:    k = j ? 2'd2 : 2'd1;
      2'd1:    k = j ? 2'd2 : 2'd0;
      default: k = j ? 2'd1 : 2'd0;
    endcase
    return k;
  endfunction

  // face axes in trial order: y, x, z
  function automatic logic [1:0] face_axis(input logic [1:0] i);
    logic [1:0] a;
    case (i)
      2'd0:    a = 2'd1;
      2'd1:    a = 2'd0;
      default: a = 2'd2;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/core/voxel_ray_cell_exit_step_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_cell_exit_step_top
// Finds where a ray leaves its unit cell, the neighbor cell and the step length.
// ----------------------------------------------------------------------------
// Pipeline from the accepting edge to the result strobe: 48 cells of
// the divider row (one quotient bit each), 21 cells of the root row, 7 stages.
// Throughput: one item per cycle; busy_o stays low, every stage advances each
// cycle and the receiver cannot stall.
// Reset: asynchronous, active low; clears all valid bits, no result follows.
// ----------------------------------------------------------------------------
module voxel_ray_cell_exit_step_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [vrc_pkg::POS_W-1:0]   pos_x_i,
  input  logic [vrc_pkg::POS_W-1:0]   pos_y_i,
  input  logic [vrc_pkg::POS_W-1:0]   pos_z_i,
  input  logic [vrc_pkg::DIR_W-1:0]   dir_x_i,
  input  logic [vrc_pkg::DIR_W-1:0]   dir_y_i,
  input  logic [vrc_pkg::DIR_W-1:0]   dir_z_i,
  input  logic [vrc_pkg::CELL_W-1:0]  cell_x_i,
  input  logic [vrc_pkg::CELL_W-1:0]  cell_y_i,
  input  logic [vrc_pkg::CELL_W-1:0]  cell_z_i,
  output logic                        valid_o,
  output logic [vrc_pkg::POS_W-1:0]   exit_x_o,
  output logic [vrc_pkg::POS_W-1:0]   exit_y_o,
  output logic [vrc_pkg::POS_W-1:0]   exit_z_o,
  output logic [vrc_pkg::CELL_W-1:0]  next_x_o,
  output logic [vrc_pkg::CELL_W-1:0]  next_y_o,
  output logic [vrc_pkg::CELL_W-1:0]  next_z_o,
  output logic [vrc_pkg::LEN_W-1:0]   step_length_o,
  output logic                        no_exit_o
);
  import vrc_pkg::*;

  localparam int LAT = QUO_W + ROOT_W + 7;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // input register
  logic                   s0_valid_q;
  logic [2:0][POS_W-1:0]  s0_pos_q;
  logic [2:0][DIR_W-1:0]  s0_dir_q;
  logic [2:0][CELL_W-1:0] s0_cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_pos_q  <= {pos_z_i, pos_y_i, pos_x_i};
    s0_dir_q  <= {dir_z_i, dir_y_i, dir_x_i};
    s0_cell_q <= {cell_z_i, cell_y_i, cell_x_i};
  end

  // plane offsets per axis
  ctx_t                  s1_d;
  ctx_t                  s1_q;
  logic                  s1_valid_q;
  logic [2:0][DIR_W-1:0] s1_dir_q;
  logic [DELTA_W-1:0]    plane;

  always_comb begin
    s1_d       = '0;
    s1_d.pos   = s0_pos_q;
    s1_d.cidx  = s0_cell_q;
    plane      = '0;
    for (int a = 0; a < 3; a++) begin
      s1_d.tried[a] = (s0_dir_q[a] != '0);
      s1_d.up[a]    = (s0_dir_q[a] != '0) && !s0_dir_q[a][DIR_W-1];
      plane = (DELTA_W'($signed(s0_cell_q[a])) + DELTA_W'(s1_d.up[a])) << FRAC_W;
      s1_d.delta[a] = plane - DELTA_W'($signed(s0_pos_q[a]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q     <= s1_d;
    s1_dir_q <= s0_dir_q;
  end

  // products and magnitudes into the divider row head
  div_t                      head_d;
  div_t                      head_q;
  logic signed [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]         pmag;
  logic [1:0]                la;
  logic [1:0]                lk;

  always_comb begin
    head_d       = '0;
    head_d.valid = s1_valid_q;
    head_d.ctx   = s1_q;
    prod = '0;
    pmag = '0;
    la   = '0;
    lk   = '0;
    for (int l = 0; l < NLANE; l++) begin
      la   = 2'(l / 2);
      lk   = other_axis(la, l[0]);
      prod = $signed(s1_q.delta[la]) * $signed(s1_dir_q[lk]);
      pmag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
      head_d.lane[l].nq  = pmag[QUO_W-1:0];
      head_d.lane[l].rem = '0;
      head_d.lane[l].den = s1_dir_q[la][DIR_W-1] ? DIR_W'(-s1_dir_q[la]) : s1_dir_q[la];
      head_d.lane[l].neg = prod[PROD_W-1] ^ s1_dir_q[la][DIR_W-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q <= head_d;
    end
  end

  div_t div_row [QUO_W+1];
  assign div_row[0] = head_q;

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    vrc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .in_i   (div_row[i]),
      .out_o  (div_row[i+1])
    );
  end

  // trial points, inside tests and face selection
  div_t                           dt;
  logic [2:0][2:0][TRIAL_W-1:0]   cand;
  logic [2:0][2:0][TRIAL_W-1:0]   dif;
  logic [2:0]                     ins;
  logic [TRIAL_W-1:0]             off;
  logic [TRIAL_W-1:0]             lo;
  logic [TRIAL_W-1:0]             hi;
  logic [1:0]                     ka;
  logic [1:0]                     fa;
  logic [2:0][TRIAL_W-1:0]        sel_trial;
  logic [2:0][TRIAL_W-1:0]        sel_dif;
  logic [2:0][CELL_W-1:0]         sel_next;
  logic                           sel_found;
  logic [TRIAL_W-1:0]             dabs;
  logic                           sel_sat;

  assign dt = div_row[QUO_W];

  always_comb begin
    cand = '0;
    dif  = '0;
    ins  = '0;
    off  = '0;
    lo   = '0;
    hi   = '0;
    ka   = '0;
    fa   = '0;
    for (int a = 0; a < 3; a++) begin
      cand[a][a] = TRIAL_W'($signed(dt.ctx.delta[a])) + TRIAL_W'($signed(dt.ctx.pos[a]));
      dif[a][a]  = TRIAL_W'($signed(dt.ctx.delta[a]));
      ins[a]     = 1'b1;
      for (int j = 0; j < 2; j++) begin
        ka  = other_axis(2'(a), j[0]);
        off = dt.lane[a*2+j].neg ? TRIAL_W'(-{4'b0, dt.lane[a*2+j].nq})
                                 : TRIAL_W'({4'b0, dt.lane[a*2+j].nq});
        cand[a][ka] = TRIAL_W'($signed(dt.ctx.pos[ka])) + off;
        dif[a][ka]  = off;
        lo = TRIAL_W'($signed(dt.ctx.cidx[ka])) << FRAC_W;
        hi = lo + (TRIAL_W'(1) << FRAC_W);
        if ($signed(cand[a][ka]) < $signed(lo) || $signed(cand[a][ka]) > $signed(hi)) begin
          ins[a] = 1'b0;
        end
      end
    end

    sel_found = 1'b0;
    sel_dif   = '0;
    sel_next  = dt.ctx.cidx;
    for (int k = 0; k < 3; k++) begin
      sel_trial[k] = TRIAL_W'($signed(dt.ctx.pos[k]));
    end
    for (int i = 0; i < 3; i++) begin
      fa = face_axis(2'(i));
      if (dt.ctx.tried[fa] && !sel_found) begin
        sel_trial = cand[fa];
        if (ins[fa]) begin
          sel_found    = 1'b1;
          sel_dif      = dif[fa];
          sel_next[fa] = dt.ctx.up[fa] ? dt.ctx.cidx[fa] + CELL_W'(1)
                                       : dt.ctx.cidx[fa] - CELL_W'(1);
        end
      end
    end
  end

  logic                   sc_valid_q;
  res_t                   sc_res_q;
  logic [2:0][LEN_W-1:0]  sc_abs_q;
  logic [2:0][LEN_W-1:0]  sc_abs_d;

  always_comb begin
    sel_sat  = 1'b0;
    dabs     = '0;
    sc_abs_d = '0;
    for (int k = 0; k < 3; k++) begin
      dabs = sel_dif[k][TRIAL_W-1] ? -sel_dif[k] : sel_dif[k];
      if (|dabs[TRIAL_W-1:LEN_W]) begin
        sel_sat = 1'b1;
      end
      sc_abs_d[k] = dabs[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_valid_q <= 1'b0;
    end else begin
      sc_valid_q <= dt.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sc_res_q.exit_p[k] <= sel_trial[k][POS_W-1:0];
    end
    sc_res_q.next_c <= sel_next;
    sc_res_q.found  <= sel_found;
    sc_res_q.sat    <= sel_sat;
    sc_abs_q        <= sc_abs_d;
  end

  // squares
  logic                  sd_valid_q;
  res_t                  sd_res_q;
  logic [2:0][SQ_W-1:0]  sd_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd_valid_q <= 1'b0;
    end else begin
      sd_valid_q <= sc_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sd_res_q <= sc_res_q;
    for (int k = 0; k < 3; k++) begin
      sd_sq_q[k] <= sc_abs_q[k] * sc_abs_q[k];
    end
  end

  // sum into the root row head
  sqrt_t sq_head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_head_q <= '0;
    end else begin
      sq_head_q.valid <= sd_valid_q;
      sq_head_q.res   <= sd_res_q;
      sq_head_q.n     <= SQ_IN_W'(sd_sq_q[0]) + SQ_IN_W'(sd_sq_q[1]) + SQ_IN_W'(sd_sq_q[2]);
      sq_head_q.rem   <= '0;
      sq_head_q.root  <= '0;
    end
  end

  sqrt_t sq_row [ROOT_W+1];
  assign sq_row[0] = sq_head_q;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    vrc_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .in_i   (sq_row[i]),
      .out_o  (sq_row[i+1])
    );
  end

  // output register
  sqrt_t             st;
  logic [LEN_W-1:0]  len_d;
  logic              valid_q;
  res_t              out_res_q;
  logic [LEN_W-1:0]  len_q;

  assign st = sq_row[ROOT_W];

  always_comb begin
    if (!st.res.found) begin
      len_d = '0;
    end else if (st.res.sat || st.root[ROOT_W-1]) begin
      len_d = '1;
    end else begin
      len_d = st.root[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= st.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= st.res;
    len_q     <= len_d;
  end

  assign valid_o       = valid_q;
  assign exit_x_o      = out_res_q.exit_p[0];
  assign exit_y_o      = out_res_q.exit_p[1];
  assign exit_z_o      = out_res_q.exit_p[2];
  assign next_x_o      = out_res_q.next_c[0];
  assign next_y_o      = out_res_q.next_c[1];
  assign next_z_o      = out_res_q.next_c[2];
  assign step_length_o = len_q;
  assign no_exit_o     = !out_res_q.found;

  // every accepted item gives its result a fixed time later
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT valid_o)
    else $error("result strobe missing after accepted item");

  // no result without an item leaving the root row
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(st.valid))
    else $error("result strobe without item");

  // divider row tail feeds the selection stage in the next cycle
  a_div_to_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dt.valid |=> sc_valid_q)
    else $error("item lost after divider row");

  // a missed exit never reports a distance
  a_no_exit_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st.valid && !st.res.found) |=> (valid_o && step_length_o == '0))
    else $error("distance reported without exit");

endmodule

// ----- rtl/core/vrc_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrc_div_cell
// One quotient bit for all six divide lanes; passes the item to the next cell.
// ----------------------------------------------------------------------------
module vrc_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vrc_pkg::div_t in_i,
  output vrc_pkg::div_t out_o
);
  import vrc_pkg::*;

  div_t           d_d;
  div_t           q_q;
  logic [DIR_W:0] r2;
  logic           qb;

  always_comb begin
    d_d = in_i;
    r2  = '0;
    qb  = 1'b0;
    for (int l = 0; l < NLANE; l++) begin
      r2 = {in_i.lane[l].rem, in_i.lane[l].nq[QUO_W-1]};
      qb = (r2 >= {1'b0, in_i.lane[l].den});
      if (qb) begin
        d_d.lane[l].rem = DIR_W'(r2 - {1'b0, in_i.lane[l].den});
      end else begin
        d_d.lane[l].rem = r2[DIR_W-1:0];
      end
      d_d.lane[l].nq = {in_i.lane[l].nq[QUO_W-2:0], qb};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else begin
      q_q <= d_d;
    end
  end

  assign out_o = q_q;

endmodule

// ----- rtl/core/vrc_sqrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrc_sqrt_cell
// One root bit of the step length; passes the item to the next cell.
// ----------------------------------------------------------------------------
module vrc_sqrt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vrc_pkg::sqrt_t in_i,
  output vrc_pkg::sqrt_t out_o
);
  import vrc_pkg::*;

  sqrt_t             d_d;
  sqrt_t             q_q;
  logic [SREM_W-1:0] r4;
  logic [SREM_W-1:0] trial;

  always_comb begin
    d_d   = in_i;
    r4    = {in_i.rem[SREM_W-3:0], in_i.n[SQ_IN_W-1 -: 2]};
    trial = SREM_W'({in_i.root, 2'b01});
    d_d.n = {in_i.n[SQ_IN_W-3:0], 2'b00};
    if (r4 >= trial) begin
      d_d.rem  = r4 - trial;
      d_d.root = {in_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      d_d.rem  = r4;
      d_d.root = {in_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else begin
      q_q <= d_d;
    end
  end

  assign out_o = q_q;

endmodule

// ----- sim/voxel_ray_cell_exit_step_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_cell_exit_step_top_tb
// Drives rays through the cell exit step block and checks every result against
// an in-bench face-exit predictor: face order, inclusive bounds, truncating
// divide, exit-point wrap, cell wrap, saturating step length and the no-exit
// case. Directed corner cases come first, then random rays with random gaps.
// ----------------------------------------------------------------------------
module voxel_ray_cell_exit_step_top_tb;
  import vrc_pkg::*;

  localparam int  LATENCY     = 76;
  localparam int  UNIT_SHIFT  = 16;
  localparam int  RAND_ITEMS  = 1600;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [POS_W-1:0]  pos [3];
    logic [DIR_W-1:0]  dir [3];
    logic [CELL_W-1:0] cidx [3];
  } ray_t;

  typedef struct {
    logic [POS_W-1:0]  exit_p [3];
    logic [CELL_W-1:0] next_c [3];
    logic [LEN_W-1:0]  len;
    logic              no_exit;
  } exit_t;

  class exit_scoreboard;
    exit_t  expected_q [$];
    int     errors;
    int     checked;
    int     exits_seen;
    int     misses_seen;

    function automatic longint unsigned isqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // work out the exit of one ray and queue it
    function void note_ray(ray_t r);
      int     axis_of [6] = '{1, 1, 0, 0, 2, 2};
      bit     up_of [6]   = '{1, 0, 1, 0, 1, 0};
      longint p [3], d [3], c [3], trial [3], diff [3], nxt [3];
      longint plane, delta, off, lo, unit, lim, s;
      longint unsigned len;
      bit     found, in_face, up;
      int     a;
      exit_t  e;
      unit = longint'(1) << UNIT_SHIFT;
      found = 0;
      for (int k = 0; k < 3; k++) begin
        p[k] = longint'($signed(r.pos[k]));
        d[k] = longint'($signed(r.dir[k]));
        c[k] = longint'($signed(r.cidx[k]));
        trial[k] = p[k];
        nxt[k] = c[k];
        diff[k] = 0;
      end
      for (int f = 0; f < 6 && !found; f++) begin
        a = axis_of[f];
        up = up_of[f];
        if (up ? !(d[a] > 0) : !(d[a] < 0)) continue;
        plane = (c[a] + (up ? 1 : 0)) * unit;
        delta = plane - p[a];
        trial[a] = plane;
        diff[a] = delta;
        in_face = 1;
        for (int k = 0; k < 3; k++) begin
          if (k == a) continue;
          off = (delta * d[k]) / d[a];
          trial[k] = p[k] + off;
          diff[k] = off;
          lo = c[k] * unit;
          if (trial[k] < lo || trial[k] > lo + unit) in_face = 0;
        end
        if (in_face) begin
          found = 1;
          nxt[a] = c[a] + (up ? 1 : -1);
        end
      end
      for (int k = 0; k < 3; k++) begin
        e.exit_p[k] = trial[k][POS_W-1:0];
        e.next_c[k] = nxt[k][CELL_W-1:0];
      end
      e.no_exit = !found;
      e.len = '0;
      if (found) begin
        lim = longint'(1) << LEN_W;
        if (diff[0] >= lim || -diff[0] >= lim || diff[1] >= lim || -diff[1] >= lim ||
            diff[2] >= lim || -diff[2] >= lim) begin
          e.len = '1;
        end else begin
          s = diff[0] * diff[0] + diff[1] * diff[1] + diff[2] * diff[2];
          len = isqrt(longint'(s));
          e.len = (len > ((64'd1 << LEN_W) - 1)) ? '1 : len[LEN_W-1:0];
        end
      end
      expected_q.push_back(e);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
      errors++;
    endtask

    task check_exit(exit_t got);
      exit_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 64'd1, 64'd0);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.no_exit) misses_seen++; else exits_seen++;
      for (int k = 0; k < 3; k++) begin
        if (got.exit_p[k] !== want.exit_p[k])
          report_mismatch($sformatf("exit[%0d]", k), got.exit_p[k], want.exit_p[k]);
        if (got.next_c[k] !== want.next_c[k])
          report_mismatch($sformatf("next[%0d]", k), got.next_c[k], want.next_c[k]);
      end
      if (got.len !== want.len) report_mismatch("step_length", got.len, want.len);
      if (got.no_exit !== want.no_exit) report_mismatch("no_exit", got.no_exit, want.no_exit);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o, valid_o, no_exit_o;
  logic [POS_W-1:0]  pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [DIR_W-1:0]  dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic [CELL_W-1:0] cell_x_i = '0, cell_y_i = '0, cell_z_i = '0;
  logic [POS_W-1:0]  exit_x_o, exit_y_o, exit_z_o;
  logic [CELL_W-1:0] next_x_o, next_y_o, next_z_o;
  logic [LEN_W-1:0]  step_length_o;

  exit_scoreboard sb = new();
  longint cycles = 0;

  voxel_ray_cell_exit_step_top i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .pos_x_i, .pos_y_i, .pos_z_i, .dir_x_i, .dir_y_i, .dir_z_i,
    .cell_x_i, .cell_y_i, .cell_z_i,
    .valid_o, .exit_x_o, .exit_y_o, .exit_z_o,
    .next_x_o, .next_y_o, .next_z_o, .step_length_o, .no_exit_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // sample both handshakes at the rising edge
  always @(posedge clk_i) begin
    ray_t  r;
    exit_t g;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("voxel_ray_cell_exit_step_top_tb: errors");
      $finish;
    end
    if (rst_ni && start_i && !busy_o) begin
      r.pos  = '{pos_x_i, pos_y_i, pos_z_i};
      r.dir  = '{dir_x_i, dir_y_i, dir_z_i};
      r.cidx = '{cell_x_i, cell_y_i, cell_z_i};
      sb.note_ray(r);
    end
    if (rst_ni && valid_o) begin
      g.exit_p  = '{exit_x_o, exit_y_o, exit_z_o};
      g.next_c  = '{next_x_o, next_y_o, next_z_o};
      g.len     = step_length_o;
      g.no_exit = no_exit_o;
      sb.check_exit(g);
    end
  end

  function automatic ray_t mk_ray(int px, int py, int pz, int dx, int dy, int dz,
                                  int cx, int cy, int cz);
    ray_t r;
    r.pos  = '{px[POS_W-1:0], py[POS_W-1:0], pz[POS_W-1:0]};
    r.dir  = '{dx[DIR_W-1:0], dy[DIR_W-1:0], dz[DIR_W-1:0]};
    r.cidx = '{cx[CELL_W-1:0], cy[CELL_W-1:0], cz[CELL_W-1:0]};
    return r;
  endfunction

  function automatic int rand_dir();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return 16384;
    if (r == 2) return -16384;
    if (r < 6) return int'($urandom_range(0, 64)) - 32;
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  function automatic int rand_cell(bit wide);
    if (wide) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 8)) - 4;
  endfunction

  // a point inside or on the boundary of cell c along one axis
  function automatic int pos_in_cell(int c);
    int frac;
    case ($urandom_range(0, 9))
      0:       frac = 0;
      1:       frac = 65536;
      2:       frac = 32768;
      default: frac = $urandom_range(0, 65536);
    endcase
    return (c << UNIT_SHIFT) + frac;
  endfunction

  function automatic ray_t rand_ray();
    int c [3], p [3];
    bit wide;
    if ($urandom_range(0, 4) == 0)
      return mk_ray($urandom, $urandom, $urandom, rand_dir(), rand_dir(), rand_dir(),
                    rand_cell(1), rand_cell(1), rand_cell(1));
    wide = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < 3; k++) begin
      c[k] = rand_cell(wide);
      p[k] = pos_in_cell(c[k]);
    end
    return mk_ray(p[0], p[1], p[2], rand_dir(), rand_dir(), rand_dir(), c[0], c[1], c[2]);
  endfunction

  task send_ray(ray_t r, int gap);
    @(negedge clk_i);
    {pos_x_i, pos_y_i, pos_z_i}    = {r.pos[0], r.pos[1], r.pos[2]};
    {dir_x_i, dir_y_i, dir_z_i}    = {r.dir[0], r.dir[1], r.dir[2]};
    {cell_x_i, cell_y_i, cell_z_i} = {r.cidx[0], r.cidx[1], r.cidx[2]};
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
    if (gap > 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  function automatic int rand_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    ray_t directed [$];
    int   wait_cycles;
    bit   quiet;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero direction, then each face alone, then tie between faces
    directed.push_back(mk_ray(32768, 32768, 32768, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_ray(32768, 32768, 32768, 0, 16384, 0, 0, 0, 0));
    directed.push_back(mk_ray(32768, 32768, 32768, 0, -16384, 0, 0, 0, 0));
    directed.push_back(mk_ray(32768, 32768, 32768, 16384, 0, 0, 0, 0, 0));
    directed.push_back(mk_ray(32768, 32768, 32768, -16384, 0, 0, 0, 0, 0));
    directed.push_back(mk_ray(32768, 32768, 32768, 0, 0, 16384, 0, 0, 0));
    directed.push_back(mk_ray(32768, 32768, 32768, 0, 0, -16384, 0, 0, 0));
    directed.push_back(mk_ray(0, 0, 0, 16384, 16384, 16384, 0, 0, 0));
    directed.push_back(mk_ray(65536, 65536, 65536, -16384, -16384, -16384, 0, 0, 0));
    directed.push_back(mk_ray(0, 0, 0, -1, -1, -1, 0, 0, 0));
    // ray far outside its cell: no face qualifies, exit keeps the last trial
    directed.push_back(mk_ray(32'h7fffffff, 32'h80000000, 0, 3, -5, 7, 10, -10, 0));
    directed.push_back(mk_ray(32'h80000000, 32'h7fffffff, 32'h7fffffff, 16384, 16384, 16384,
                              0, 0, 0));
    // cell at the edge: next cell wraps
    directed.push_back(mk_ray(32'h7fff8000, 32768, 32768, 16384, 0, 0, 32767, 0, 0));
    directed.push_back(mk_ray(32'h80008000, 32768, 32768, -16384, 0, 0, -32768, 0, 0));
    directed.push_back(mk_ray(32768, 32'h7fff8000, 32768, 1, 16384, -1, 0, 32767, 0));
    directed.push_back(mk_ray(32768, 32768, 32'h80008000, 1, 1, -16384, 0, 0, -32768));
    // large steps and long trials for the step length
    directed.push_back(mk_ray(32'h80000000, 0, 0, 16384, 1, 1, 0, 0, 0));
    directed.push_back(mk_ray(-32'sd20000000, 0, 0, 16384, 0, 0, -300, 0, 0));
    directed.push_back(mk_ray(32768, 32768, 32768, 1, 16384, 16383, 0, 0, 0));
    directed.push_back(mk_ray(1, 65535, 1, -1, 16384, 1, 0, 0, 0));
    directed.push_back(mk_ray(-1, -1, -1, 16384, -16384, 16384, -1, -1, -1));
    foreach (directed[i]) send_ray(directed[i], rand_gap(0));

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 200 == 0) quiet = ($urandom_range(0, 2) == 0);
      send_ray(rand_ray(), rand_gap(quiet));
    end
    @(negedge clk_i);
    start_i = 1'b0;

    wait_cycles = 0;
    while (sb.expected_q.size() != 0 && wait_cycles < 4 * LATENCY) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (LATENCY + 4) @(posedge clk_i);
    if (sb.expected_q.size() != 0)
      sb.report_mismatch("results still outstanding", sb.expected_q.size(), 0);

    $display("checked %0d results: %0d rays left their cell, %0d found no exit",
             sb.checked, sb.exits_seen, sb.misses_seen);
    if (sb.errors == 0) begin
      $display("voxel_ray_cell_exit_step_top_tb: clean");
    end else begin
      $display("voxel_ray_cell_exit_step_top_tb: errors");
    end
    $finish;
  end

endmodule
